// ===== rtl/gbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibrator package
// Shared widths, constants and types for the calibrator lanes, the register
// port and the top level.
// ----------------------------------------------------------------------------
package gbc_pkg;

	localparam int SAMPLE_COUNT  = 256;
	localparam int AXES          = 3;
	localparam int DATA_W        = 16;
	localparam int SUM_W         = 24;
	localparam int CNT_W         = $clog2(SAMPLE_COUNT + 1);
	localparam int BIAS_SHIFT    = $clog2(SAMPLE_COUNT + 1) - 1;
	localparam int EARLY_SAMPLES = 10;
	localparam int STEP_W        = $clog2(SUM_W + 1);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [DATA_W-1:0]        thresh_t;

	localparam cnt_t    CNT_FULL     = CNT_W'(SAMPLE_COUNT);
	localparam cnt_t    CNT_EARLY    = CNT_W'(EARLY_SAMPLES);
	localparam cnt_t    CNT_LAST     = CNT_W'(1);
	localparam thresh_t THRESH_RESET = DATA_W'(50);

	localparam logic REG_STABILITY_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic acc;
		logic latch;
	} lane_ctl_t;

	typedef struct packed {
		logic done;
		logic over;
	} lane_stat_t;

endpackage

// ===== rtl/gbc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibrator axis lane
// Holds one axis sum and bias, divides the sum by the sample count one
// quotient bit per cycle and checks the sample against the running mean.
// ----------------------------------------------------------------------------
module gbc_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  gbc_pkg::lane_ctl_t  ctl,
	input  gbc_pkg::cnt_t       divisor,
	input  gbc_pkg::data_t      gyro,
	input  gbc_pkg::thresh_t    threshold,
	output gbc_pkg::lane_stat_t stat,
	output gbc_pkg::data_t      corrected
);
	import gbc_pkg::*;

	sum_t                    sum_q;
	data_t                   bias_q;
	logic                    busy_q;
	logic [STEP_W-1:0]       step_q;
	logic                    fin_q;
	logic                    chk_s1;
	logic [SUM_W-1:0]        dq_q;
	cnt_t                    rem_q;
	logic                    neg_q;
	logic signed [DATA_W:0]  diff_s1;

	sum_t                    sum_next;
	sum_t                    sum_shifted;
	logic [SUM_W-1:0]        sum_mag;
	logic [CNT_W:0]          trial;
	logic                    ge;
	cnt_t                    rem_next;
	logic [DATA_W-1:0]       mean16;
	logic signed [DATA_W:0]  diff;
	logic [DATA_W:0]         diff_abs;

	assign sum_next    = sum_q + SUM_W'(gyro);
	assign sum_shifted = sum_next >>> BIAS_SHIFT;
	assign sum_mag     = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign rem_next = ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];

	assign mean16   = neg_q ? (~dq_q[DATA_W-1:0] + DATA_W'(1)) : dq_q[DATA_W-1:0];
	assign diff     = {gyro[DATA_W-1], gyro} - {mean16[DATA_W-1], mean16};
	assign diff_abs = diff_s1[DATA_W] ? (~diff_s1 + (DATA_W+1)'(1)) : diff_s1;

	assign stat.done = chk_s1;
	assign stat.over = diff_abs > {1'b0, threshold};
	assign corrected = gyro - bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			bias_q <= '0;
			busy_q <= 1'b0;
			step_q <= '0;
			fin_q  <= 1'b0;
			chk_s1 <= 1'b0;
		end else begin
			if (ctl.clear) begin
				sum_q <= '0;
			end else if (ctl.acc) begin
				sum_q <= sum_next;
			end
			if (ctl.latch) begin
				bias_q <= sum_shifted[DATA_W-1:0];
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			fin_q  <= busy_q && (step_q == STEP_W'(1));
			chk_s1 <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end else if (busy_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
		if (fin_q) begin
			diff_s1 <= diff;
		end
	end

endmodule

// ===== rtl/gbc_apb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibrator register port
// APB-style access to the stability threshold register.
// ----------------------------------------------------------------------------
module gbc_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gbc_pkg::APB_AW-1:0]  paddr,
	input  logic [gbc_pkg::APB_DW-1:0]  pwdata,
	output logic [gbc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output gbc_pkg::thresh_t            threshold
);
	import gbc_pkg::*;

	thresh_t threshold_q;
	logic    reg_idx;
	logic    wr_en;

	assign reg_idx   = paddr[APB_AW-1];
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;
	assign threshold = threshold_q;

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_STABILITY_THRESHOLD) begin
			prdata = APB_DW'(threshold_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (wr_en && (reg_idx == REG_STABILITY_THRESHOLD)) begin
			threshold_q <= pwdata[DATA_W-1:0];
		end
	end

endmodule

// ===== rtl/gyro_bias_calibrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibrator
// Estimates the gyro bias over a still period and removes it from the samples.
// ----------------------------------------------------------------------------
// Input transfers carry either a start command (func high) or one gyro and
// accel sample. A start command restarts calibration and gives no result.
// While calibrating, each sample after the first eleven is compared with the
// running mean on every axis; three lanes each divide their axis sum by the
// number of samples taken with a one-bit-per-cycle divider and the merge logic
// restarts calibration on motion, dropping that sample. Other samples give one
// result with zero gyro and the calibrating flag; the last one also flags
// bias_ready. After calibration, gyro results are the samples minus the bias.
// A sample that needs the stillness check passes through the 24-step divider
// and the finish and check registers of each lane before the commit state;
// any other sample goes straight to the commit state, which places the result
// in the output register; a start command keeps the port idle. A new item
// is accepted once the previous one has been placed in the output register,
// so a result may wait for the receiver while the next item is being worked
// on; a stalled receiver holds the result and, behind it, at most one item.
// Reset restarts calibration, clears the bias and sets the threshold to 50.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gbc_pkg::APB_AW-1:0]  paddr,
	input  logic [gbc_pkg::APB_DW-1:0]  pwdata,
	output logic [gbc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  gbc_pkg::data_t              gyro_x_in,
	input  gbc_pkg::data_t              gyro_y_in,
	input  gbc_pkg::data_t              gyro_z_in,
	input  gbc_pkg::data_t              accel_x_in,
	input  gbc_pkg::data_t              accel_y_in,
	input  gbc_pkg::data_t              accel_z_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output gbc_pkg::data_t              gyro_x_out,
	output gbc_pkg::data_t              gyro_y_out,
	output gbc_pkg::data_t              gyro_z_out,
	output gbc_pkg::data_t              accel_x_out,
	output gbc_pkg::data_t              accel_y_out,
	output gbc_pkg::data_t              accel_z_out,
	output logic                        calibrating,
	output logic                        bias_ready
);
	import gbc_pkg::*;

	state_t     state_q;
	state_t     state_next;
	cnt_t       left_q;
	data_t      gyro_q [AXES];
	data_t      accel_q [AXES];
	data_t      gyro_out_q [AXES];
	data_t      accel_out_q [AXES];
	logic       cal_q;
	logic       ready_q;
	logic       out_valid_q;

	thresh_t    threshold;
	lane_ctl_t  lane_ctl;
	lane_stat_t stat [AXES];
	data_t      corr [AXES];
	logic [AXES-1:0] done_vec;
	logic [AXES-1:0] over_vec;
	logic       done_all;
	logic       over_any;
	cnt_t       taken;
	logic       calib;
	logic       accept;
	logic       need_div;
	logic       fire;

	gbc_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	for (genvar gi = 0; gi < AXES; gi++) begin : g_lane
		gbc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.divisor   (taken),
			.gyro      (gyro_q[gi]),
			.threshold (threshold),
			.stat      (stat[gi]),
			.corrected (corr[gi])
		);
		assign done_vec[gi] = stat[gi].done;
		assign over_vec[gi] = stat[gi].over;
	end

	assign done_all = &done_vec;
	assign over_any = |over_vec;
	assign taken    = CNT_FULL - left_q;
	assign calib    = left_q != '0;
	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign need_div = calib && (taken > CNT_EARLY);
	assign fire     = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !func) begin
					state_next = need_div ? ST_DIV : ST_COMMIT;
				end
			end
			ST_DIV: begin
				if (done_all) begin
					state_next = over_any ? ST_IDLE : ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (fire) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctl.start = accept && !func && need_div;
		lane_ctl.clear = (accept && func) || ((state_q == ST_DIV) && done_all && over_any);
		lane_ctl.acc   = fire && calib;
		lane_ctl.latch = fire && calib && (left_q == CNT_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= CNT_FULL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (lane_ctl.clear) begin
				left_q <= CNT_FULL;
			end else if (lane_ctl.acc) begin
				left_q <= left_q - CNT_LAST;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !func) begin
			gyro_q[0]  <= gyro_x_in;
			gyro_q[1]  <= gyro_y_in;
			gyro_q[2]  <= gyro_z_in;
			accel_q[0] <= accel_x_in;
			accel_q[1] <= accel_y_in;
			accel_q[2] <= accel_z_in;
		end
		if (fire) begin
			for (int i = 0; i < AXES; i++) begin
				gyro_out_q[i]  <= calib ? data_t'(0) : corr[i];
				accel_out_q[i] <= accel_q[i];
			end
			cal_q   <= calib;
			ready_q <= calib && (left_q == CNT_LAST);
		end
	end

	assign out_valid   = out_valid_q;
	assign gyro_x_out  = gyro_out_q[0];
	assign gyro_y_out  = gyro_out_q[1];
	assign gyro_z_out  = gyro_out_q[2];
	assign accel_x_out = accel_out_q[0];
	assign accel_y_out = accel_out_q[1];
	assign accel_z_out = accel_out_q[2];
	assign calibrating = cal_q;
	assign bias_ready  = ready_q;

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(done_vec) == 0) || ($countones(done_vec) == AXES))
		else $error("axis lanes finished their checks at different times");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= CNT_FULL)
		else $error("sample counter beyond the calibration length");

	a_div_needs_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (calib && (taken > CNT_EARLY)))
		else $error("stillness check running outside calibration");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func) |=> (left_q == CNT_FULL))
		else $error("start command did not restart calibration");

	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (state_q == ST_COMMIT)) |=> (state_q == ST_COMMIT))
		else $error("result committed over a stalled output transfer");

endmodule
